### rtl/pixel_sampler_without_replacement_unit_assert.svh
// Assertion macros for the sampler top-level RTL.
// PSW_ASSERT checks a property on every rising clock edge outside reset.
// PSW_ASSERT_NEXT checks that a condition in one cycle implies another in the next.
`ifndef PIXEL_SAMPLER_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH
`define PIXEL_SAMPLER_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PSW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pixel sampler assertion failed");
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel sampler assertion failed");
`else
`define PSW_ASSERT(label, clk, rst_n, prop)
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/psw_pkg.sv
`timescale 1ns / 1ps
package psw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FRAME_W    = 9;
  localparam int SPF_W      = 17;
  localparam int DVD_W      = 31;
  localparam int POS_W      = 8;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 9'd256;
  localparam logic [SPF_W-1:0]   SPF_RST          = 17'd1;

  localparam logic ACT_NEW_FRAME = 1'b0;
  localparam logic ACT_DRAW      = 1'b1;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SAMPLES      = 2'd2
  } psw_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_RD_LAST,
    ST_WRITE,
    ST_DONE
  } psw_state_t;

  typedef struct packed {
    logic             action;
    logic [DVD_W-1:0] random_value;
  } psw_in_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last;
    logic             status;
  } psw_out_t;

endpackage

### rtl/pixel_sampler_without_replacement_unit.sv
`timescale 1ns / 1ps
`include "pixel_sampler_without_replacement_unit_assert.svh"
// Random pixel sampler without replacement.
// Configuration: write frame_width, frame_height and samples_per_frame through
// cfg_we/cfg_index/cfg_wdata while the block is idle. Sizes take effect at the
// next new frame; the sample count applies at once.
// Input beats carry an action. A new-frame beat produces no result and rewrites
// the coordinate pool, one memory write per cycle, holding in_stall high while
// it writes width*height entries (width and height saturated to MAX_WIDTH and
// MAX_HEIGHT). A draw beat yields one result beat: the serial modulo unit runs,
// and its final cycle also reads the chosen entry; then the last entry is read,
// written back into the hole, and the result is loaded into the output register.
// A draw on an empty pool skips the divider and returns status 1 (STAT_EMPTY).
// One item is processed at a time, so a draw finishes before the next is taken.
// Results sit in an output register; while out_stall is high that beat holds and
// a following finished draw waits until the register frees up, but the next
// input beat is already accepted while an earlier result waits.
// Reset empties the pool, clears the draw count and restores the register
// defaults; in_stall stays high while rst_n is low. The pool memory needs no
// clearing.
module pixel_sampler_without_replacement_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psw_pkg::psw_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psw_pkg::psw_out_t             out_data
);
  import psw_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PS_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WC_W   = $clog2(MAX_WIDTH + 1);
  localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ENT_W  = XW + YW;

  psw_state_t state_r, state_nxt;

  logic [FRAME_W-1:0] frame_width_r;
  logic [FRAME_W-1:0] frame_height_r;
  logic [SPF_W-1:0]   spf_r;

  logic [PS_W-1:0]   pool_size_r;
  logic [SPF_W-1:0]  draws_done_r;
  logic [SPF_W-1:0]  draws_nxt;
  logic [WC_W-1:0]   w_sat, w_r;
  logic [HC_W-1:0]   h_sat, h_r;
  logic [XW-1:0]     x_r;
  logic [YW-1:0]     y_r;
  logic              x_last, y_last;
  logic [ADDR_W-1:0] sel_idx_r;
  logic [ENT_W-1:0]  entry_r;
  psw_out_t          res_r;
  psw_out_t          out_data_r;
  logic              out_valid_r;
  logic              out_load;

  logic              in_accept;
  logic              div_start;
  logic              div_done;
  logic [PS_W-1:0]   div_rem;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign draws_nxt = draws_done_r + SPF_W'(1);

  // Frame sizes above the pool dimensions are clipped at refill time.
  always_comb begin
    if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_sat = WC_W'(MAX_WIDTH);
    end else begin
      w_sat = WC_W'(frame_width_r);
    end
    if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_sat = HC_W'(MAX_HEIGHT);
    end else begin
      h_sat = HC_W'(frame_height_r);
    end
  end

  assign x_last = (WC_W'(x_r) + WC_W'(1)) == w_r;
  assign y_last = (HC_W'(y_r) + HC_W'(1)) == h_r;

  psw_divider #(
    .DVS_W (PS_W)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_data.random_value),
    .divisor   (pool_size_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  psw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.action == ACT_NEW_FRAME) begin
            if (w_sat == '0 || h_sat == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_FILL;
            end
          end else if (pool_size_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_FILL: begin
        if (x_last && y_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RD_LAST;
        end
      end
      ST_RD_LAST: state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory, divider and output-register control.
  always_comb begin
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(pool_size_r);
    ram_wdata = {x_r, y_r};
    ram_raddr = ADDR_W'(div_rem);
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        div_start = in_accept && (in_data.action == ACT_DRAW) && (pool_size_r != '0);
      end
      ST_FILL: ram_we = 1'b1;
      ST_RD_LAST: ram_raddr = ADDR_W'(pool_size_r - PS_W'(1));
      ST_WRITE: begin
        // The last entry fills the hole left by the drawn one.
        ram_we    = 1'b1;
        ram_waddr = sel_idx_r;
        ram_wdata = ram_rdata;
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      spf_r          <= SPF_RST;
      pool_size_r    <= '0;
      draws_done_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FRAME_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FRAME_W-1:0];
          CFG_SAMPLES:      spf_r          <= cfg_wdata[SPF_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept && in_data.action == ACT_NEW_FRAME) begin
            pool_size_r  <= '0;
            draws_done_r <= '0;
          end
        end
        ST_FILL: pool_size_r <= pool_size_r + PS_W'(1);
        ST_WRITE: begin
          pool_size_r  <= pool_size_r - PS_W'(1);
          draws_done_r <= draws_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          w_r          <= w_sat;
          h_r          <= h_sat;
          x_r          <= '0;
          y_r          <= '0;
          res_r.pos_x  <= '0;
          res_r.pos_y  <= '0;
          res_r.last   <= 1'b0;
          res_r.status <= STAT_EMPTY;
        end
      end
      ST_FILL: begin
        if (y_last) begin
          y_r <= '0;
          x_r <= x_r + XW'(1);
        end else begin
          y_r <= y_r + YW'(1);
        end
      end
      ST_DIV: sel_idx_r <= ADDR_W'(div_rem);
      ST_RD_LAST: entry_r <= ram_rdata;
      ST_WRITE: begin
        res_r.pos_x  <= POS_W'(entry_r[ENT_W-1 -: XW]);
        res_r.pos_y  <= POS_W'(entry_r[YW-1:0]);
        res_r.last   <= (spf_r != '0) && (draws_nxt == spf_r);
        res_r.status <= STAT_OK;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  `PSW_ASSERT(a_pool_bound, clk, rst_n, pool_size_r <= PS_W'(DEPTH))
  `PSW_ASSERT(a_rem_in_pool, clk, rst_n, div_done |-> (div_rem < pool_size_r))
  `PSW_ASSERT_NEXT(a_draw_shrinks, clk, rst_n, state_r == ST_WRITE, pool_size_r == $past(pool_size_r) - PS_W'(1))
  `PSW_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE))

endmodule

### rtl/psw_ram.sv
`timescale 1ns / 1ps
module psw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/psw_divider.sv
`timescale 1ns / 1ps
module psw_divider #(
  parameter int DVS_W = 17
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [psw_pkg::DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]         divisor,
  output logic                     done,
  output logic [DVS_W-1:0]         remainder
);
  import psw_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;

  // Restoring remainder: one dividend bit enters per cycle, most significant first.
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = DVS_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### test/tb_pixel_sampler_without_replacement_unit.sv
`timescale 1ns / 1ps
module tb_pixel_sampler_without_replacement_unit;
  import psw_pkg::*;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  psw_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psw_out_t out_data;

  pixel_sampler_without_replacement_unit #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Shadow copy of the block's registers and pool.
  logic [FRAME_W-1:0] shadow_width = FRAME_WIDTH_RST;
  logic [FRAME_W-1:0] shadow_height = FRAME_HEIGHT_RST;
  logic [SPF_W-1:0] shadow_spf = SPF_RST;
  bit [15:0] sample_pool [0:MAX_W*MAX_H-1];
  int unsigned pool_count = 0;
  logic [SPF_W-1:0] draw_count = '0;

  psw_in_t stim_items[$];
  psw_out_t expected_beats[$];
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  bit rx_blocked = 1'b0;
  longint unsigned cycle_count = 0;
  longint unsigned fill_done_cycle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic predict_sample(input psw_in_t beat);
    int unsigned w, h, k, pick, x, y;
    psw_out_t res;
    if (beat.action == ACT_NEW_FRAME) begin
      w = (shadow_width > MAX_W) ? MAX_W : shadow_width;
      h = (shadow_height > MAX_H) ? MAX_H : shadow_height;
      k = 0;
      for (x = 0; x < w; x++) begin
        for (y = 0; y < h; y++) begin
          sample_pool[k] = {8'(x), 8'(y)};
          k++;
        end
      end
      pool_count = k;
      draw_count = '0;
      fill_done_cycle = cycle_count + w * h + 64;
    end else begin
      res = '0;
      if (pool_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        pick = beat.random_value % pool_count;
        res.pos_x = sample_pool[pick][15:8];
        res.pos_y = sample_pool[pick][7:0];
        sample_pool[pick] = sample_pool[pool_count-1];
        pool_count--;
        draw_count = draw_count + 1'b1;
        res.last = (shadow_spf != 0) && (draw_count == shadow_spf);
        res.status = STAT_OK;
      end
      expected_beats.insert(expected_beats.size(), res);
    end
  endtask

  // Sender: a new beat is offered only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_sample(in_data);
      if (!in_valid || !in_stall) begin
        if (stim_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= stim_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    psw_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: pos_x %0d pos_y %0d last %0d status %0d",
                 out_data.pos_x, out_data.pos_y, out_data.last, out_data.status);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.pos_x !== want.pos_x) begin
            $error("pos_x mismatch: expected %0d, actual %0d", want.pos_x, out_data.pos_x);
            err_count++;
          end
          if (out_data.pos_y !== want.pos_y) begin
            $error("pos_y mismatch: expected %0d, actual %0d", want.pos_y, out_data.pos_y);
            err_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_data.last);
            err_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            err_count++;
          end
        end
      end
      out_stall <= rx_blocked || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin : rx_hold_ctl
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rx_blocked = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_blocked = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FRAME_WIDTH:  shadow_width = val[FRAME_W-1:0];
      CFG_FRAME_HEIGHT: shadow_height = val[FRAME_W-1:0];
      CFG_SAMPLES:      shadow_spf = val[SPF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every beat is sent and answered and any refill has run out.
  task automatic wait_quiet();
    do @(negedge clk);
    while (stim_items.size() != 0 || in_valid || expected_beats.size() != 0);
    while (cycle_count < fill_done_cycle) @(negedge clk);
  endtask

  task automatic queue_item(input logic act, input logic [DVD_W-1:0] rv);
    psw_in_t item;
    item.action = act;
    item.random_value = rv;
    stim_items.insert(stim_items.size(), item);
  endtask

  function automatic logic [DVD_W-1:0] rand_rv();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DVD_W'($urandom_range(0, 300));
      default: return DVD_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [FRAME_W-1:0] d;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) d = '0;
    else if (r < 10) d = FRAME_W'($urandom_range(200, 511));
    else d = FRAME_W'($urandom_range(1, 12));
    // Bits above the register width must be dropped by the block.
    if ($urandom_range(0, 3) == 0) return {8'($urandom()), d};
    return {8'h00, d};
  endfunction

  function automatic int unsigned pool_of_config();
    int unsigned w, h;
    w = (shadow_width > MAX_W) ? MAX_W : shadow_width;
    h = (shadow_height > MAX_H) ? MAX_H : shadow_height;
    return w * h;
  endfunction

  task automatic random_config();
    int unsigned pool;
    int r;
    write_reg(CFG_FRAME_WIDTH, pick_dim());
    write_reg(CFG_FRAME_HEIGHT, pick_dim());
    pool = pool_of_config();
    r = $urandom_range(0, 99);
    if (r < 20) write_reg(CFG_SAMPLES, '0);
    else if (r < 25) write_reg(CFG_SAMPLES, '1);
    else if (r < 30) write_reg(CFG_SAMPLES, 17'd65536);
    else write_reg(CFG_SAMPLES, CFG_DATA_W'($urandom_range(1, pool + 1)));
    end_writes();
  endtask

  // Mostly a new frame followed by a run of draws; the rest is loose beats.
  task automatic build_batch(input int n);
    int count, k, kmax, i;
    count = 0;
    while (count < n) begin
      if (n - count >= 2 && $urandom_range(0, 99) < 80) begin
        queue_item(ACT_NEW_FRAME, DVD_W'($urandom()));
        kmax = pool_of_config() + 2;
        if (kmax > 40) kmax = 40;
        if (kmax > n - count - 1) kmax = n - count - 1;
        k = $urandom_range(1, kmax);
        for (i = 0; i < k; i++) queue_item(ACT_DRAW, rand_rv());
        count += k + 1;
      end else begin
        queue_item(1'($urandom()), rand_rv());
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int p, s;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: a draw on the empty pool, then a full-size frame.
    queue_item(ACT_DRAW, '1);
    queue_item(ACT_NEW_FRAME, '0);
    queue_item(ACT_DRAW, '0);
    queue_item(ACT_DRAW, '1);
    queue_item(ACT_DRAW, rand_rv());
    wait_quiet();

    // Zero sample count, with garbage above the width field.
    write_reg(CFG_FRAME_WIDTH, 17'h1FE02);
    write_reg(CFG_FRAME_HEIGHT, 17'd1);
    write_reg(CFG_SAMPLES, '0);
    end_writes();
    queue_item(ACT_NEW_FRAME, '1);
    queue_item(ACT_DRAW, rand_rv());
    wait_quiet();

    // Mid-frame change: the old pool stays, the new count applies at once.
    write_reg(CFG_FRAME_WIDTH, 17'd1);
    write_reg(CFG_FRAME_HEIGHT, 17'd300);
    write_reg(CFG_SAMPLES, 17'd2);
    end_writes();
    queue_item(ACT_DRAW, rand_rv());
    queue_item(ACT_DRAW, rand_rv());
    queue_item(ACT_NEW_FRAME, '0);
    queue_item(ACT_DRAW, '1);
    queue_item(ACT_DRAW, '0);
    wait_quiet();

    // Zero width leaves the pool empty.
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, 17'd5);
    write_reg(CFG_SAMPLES, '1);
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom()));
    end_writes();
    queue_item(ACT_NEW_FRAME, '0);
    queue_item(ACT_DRAW, rand_rv());
    wait_quiet();

    // Oversized width saturates.
    write_reg(CFG_FRAME_WIDTH, 17'd511);
    write_reg(CFG_FRAME_HEIGHT, 17'd2);
    write_reg(CFG_SAMPLES, 17'd65536);
    end_writes();
    queue_item(ACT_NEW_FRAME, '0);
    queue_item(ACT_DRAW, '1);
    queue_item(ACT_DRAW, rand_rv());
    queue_item(ACT_DRAW, rand_rv());
    queue_item(ACT_DRAW, '0);
    wait_quiet();

    // Receiver holds off while the sender keeps offering, so input backs up.
    write_reg(CFG_FRAME_WIDTH, 17'd6);
    write_reg(CFG_FRAME_HEIGHT, 17'd5);
    write_reg(CFG_SAMPLES, 17'd10);
    end_writes();
    hold_req = 1'b1;
    queue_item(ACT_NEW_FRAME, '0);
    repeat (25) queue_item(ACT_DRAW, rand_rv());
    wait_quiet();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      for (s = 0; s < 5; s++) begin
        random_config();
        build_batch(28);
        // The sender pauses here until every result is back.
        wait_quiet();
        build_batch(28);
        wait_quiet();
      end
    end

    repeat (64) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("pixel_sampler_without_replacement_unit regression: pass");
    end else begin
      $display("pixel_sampler_without_replacement_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("pixel_sampler_without_replacement_unit regression: fail");
    $finish;
  end

endmodule
